### sv/ntc_pkg.sv
// ----------------------------------------------------------------------------
// ntc_pkg
// Shared types, widths and constants of the NTC thermistor temperature
// converter pipeline.
// ----------------------------------------------------------------------------
package ntc_pkg;

  localparam int unsigned AdcBits     = 12;
  localparam int unsigned ResBits     = 20;
  localparam int unsigned CoefBits    = 48;
  localparam int unsigned TempBits    = 24;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned LogFracBits = 24;
  localparam int unsigned DiffW       = 32;
  localparam int unsigned LmagW       = 21;
  localparam int unsigned L2W         = 42;
  localparam int unsigned L3W         = 47;
  localparam int unsigned DenW        = 63;
  localparam int unsigned QuotBits    = 32;
  localparam int unsigned DivStepBits = 2;
  localparam int unsigned KelvinW     = 34;
  localparam int unsigned SatShift    = 24;

  localparam logic [31:0] Ln2Q32 = 32'd2977044472;
  localparam logic signed [KelvinW-1:0] KelvinQ16 = 34'sd17901158;
  localparam logic signed [KelvinW-1:0] TempRound = 34'sd128;
  localparam logic signed [TempBits-1:0] TempMax = 24'sh7FFFFF;
  localparam logic signed [TempBits-1:0] TempMin = -24'sh800000;
  localparam logic [DenW-1:0] RemInit = DenW'(64'd1 << SatShift);

  localparam int unsigned FullScaleRst = 4095;
  localparam logic [ResBits-1:0] DivResRst = 20'd1000;
  localparam logic signed [CoefBits-1:0] CoefARst = 48'sd11651736815;
  localparam logic [CoefBits-1:0] CoefBMagRst = 48'd2600987715;
  localparam logic CoefBNegRst = 1'b1;
  localparam logic [CoefBits-1:0] CoefDMagRst = 48'd29251170;
  localparam logic CoefDNegRst = 1'b0;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgFullScale = 3'd0,
    CfgDivRes    = 3'd1,
    CfgCoeffA    = 3'd2,
    CfgCoeffB    = 3'd3,
    CfgCoeffD    = 3'd4
  } ntc_cfg_e;

  typedef struct packed {
    logic vld;
    logic ok;
    logic sat;
  } ntc_ctl_t;

endpackage

### sv/ntc_adc_to_temperature.sv
// ----------------------------------------------------------------------------
// ntc_adc_to_temperature
// NTC divider ADC sample to temperature (Steinhart-Hart), fixed point.
//
// Input: a sample transfer happens at each clock edge with start high and
// busy low; busy stays low, so one sample can enter every cycle.
// Output: each result is shown on temperature_o / valid_res_o for exactly
// one cycle with done_o high, in input order. The receiver cannot stall;
// there is no backpressure.
// Throughput is one sample per cycle, set by the fully pipelined log2
// squaring rounds (24 stages) and the divider (16 stages, 2 bits each).
// Configuration: register writes on the cfg channel (always ready); unknown
// indexes are dropped. The user must write only while no sample is in
// flight; the block itself does not enforce it.
// Reset clears all pipeline valid bits and loads the default registers;
// no result is lost or repeated since nothing ever waits.
// ----------------------------------------------------------------------------
module ntc_adc_to_temperature
  import ntc_pkg::*;
#(
  parameter int unsigned ADC_BITS = AdcBits
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [ADC_BITS-1:0]        adc_sample_i,
  output logic                       done_o,
  output logic signed [TempBits-1:0] temperature_o,
  output logic                       valid_res_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CfgIdxBits-1:0]      cfg_index_i,
  input  logic [CoefBits-1:0]        cfg_data_i
);

  localparam int unsigned XW = ADC_BITS + ResBits;

  // configuration registers
  logic [ADC_BITS-1:0]        fs_q;
  logic [ResBits-1:0]         r1_q;
  logic signed [CoefBits-1:0] coef_a_q;
  logic [CoefBits-1:0]        b_mag_q, d_mag_q;
  logic                       b_neg_q, d_neg_q;
  logic [CoefBits-1:0]        cfg_mag;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign cfg_mag     = cfg_data_i[CoefBits-1] ? CoefBits'(-cfg_data_i) : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q     <= ADC_BITS'(FullScaleRst);
      r1_q     <= DivResRst;
      coef_a_q <= CoefARst;
      b_mag_q  <= CoefBMagRst;
      b_neg_q  <= CoefBNegRst;
      d_mag_q  <= CoefDMagRst;
      d_neg_q  <= CoefDNegRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgFullScale: fs_q <= cfg_data_i[ADC_BITS-1:0];
        CfgDivRes:    r1_q <= cfg_data_i[ResBits-1:0];
        CfgCoeffA:    coef_a_q <= cfg_data_i;
        CfgCoeffB: begin
          b_mag_q <= cfg_mag;
          b_neg_q <= cfg_data_i[CoefBits-1];
        end
        CfgCoeffD: begin
          d_mag_q <= cfg_mag;
          d_neg_q <= cfg_data_i[CoefBits-1];
        end
        default: ;
      endcase
    end
  end

  // pipeline control
  ntc_ctl_t a_ctl_q, b_ctl_q, ld_ctl, c_ctl_q, d_ctl_q, e_ctl_q, f_ctl_q, g_ctl_q;
  ntc_ctl_t h_ctl_q, i_ctl_q, j_ctl_q, k_ctl_q, l_ctl_q, m_ctl_q, dv_ctl;
  ntc_ctl_t a_ctl_d, m_ctl_d;

  // pipeline payload
  logic [ADC_BITS-1:0]     a_s_q, a_diff_q, b_x2_q;
  logic [XW-1:0]           b_x1_q;
  logic signed [DiffW-1:0] ld_diff;
  logic [DiffW-1:0]        c_mag_q;
  logic                    c_neg_q, d_neg_q2;
  logic [63:0]             d_prod_q;
  logic [LmagW-1:0]        e_lmag_q, f_lmag_q, g_lmag_q, h_lmag_q;
  logic                    e_lneg_q, f_lneg_q, g_lneg_q, h_lneg_q;
  logic [L2W-1:0]          f_l2_q;
  logic [L2W+LmagW-1:0]    g_p3_q;
  logic [L3W-1:0]          h_l3_q;
  logic [52:0]             i_pb_lo_q;
  logic [36:0]             i_pb_hi_q;
  logic [47:0]             i_pd00_q, i_pd10_q;
  logic [46:0]             i_pd01_q, i_pd11_q;
  logic                    i_bneg_q, i_dneg_q, j_bneg_q, j_dneg_q;
  logic [68:0]             j_sb_q;
  logic [94:0]             j_sd_q;
  logic [52:0]             k_t1_mag;
  logic [62:0]             k_t2_mag;
  logic signed [63:0]      k_t1_q, k_t2_q, l_den_q;
  logic [DenW-1:0]         m_den_q;
  logic [QuotBits-1:0]     dv_quot;

  always_comb begin
    a_ctl_d.vld = start;
    a_ctl_d.ok  = (adc_sample_i != '0) && (adc_sample_i < fs_q) && (r1_q != '0);
    a_ctl_d.sat = 1'b0;
  end

  assign k_t1_mag = 53'((j_sb_q + 69'(1 << 15)) >> 16);
  assign k_t2_mag = 63'((j_sd_q + (95'd1 << 31)) >> 32);

  always_comb begin
    m_ctl_d     = l_ctl_q;
    m_ctl_d.ok  = l_ctl_q.ok && !l_den_q[63] && (l_den_q != '0);
    m_ctl_d.sat = (l_den_q[DenW-1:0] <= RemInit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_ctl_q <= '0;
      b_ctl_q <= '0;
      c_ctl_q <= '0;
      d_ctl_q <= '0;
      e_ctl_q <= '0;
      f_ctl_q <= '0;
      g_ctl_q <= '0;
      h_ctl_q <= '0;
      i_ctl_q <= '0;
      j_ctl_q <= '0;
      k_ctl_q <= '0;
      l_ctl_q <= '0;
      m_ctl_q <= '0;
    end else begin
      a_ctl_q <= a_ctl_d;
      b_ctl_q <= a_ctl_q;
      c_ctl_q <= ld_ctl;
      d_ctl_q <= c_ctl_q;
      e_ctl_q <= d_ctl_q;
      f_ctl_q <= e_ctl_q;
      g_ctl_q <= f_ctl_q;
      h_ctl_q <= g_ctl_q;
      i_ctl_q <= h_ctl_q;
      j_ctl_q <= i_ctl_q;
      k_ctl_q <= j_ctl_q;
      l_ctl_q <= k_ctl_q;
      m_ctl_q <= m_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_s_q    <= adc_sample_i;
    a_diff_q <= fs_q - adc_sample_i;
    b_x1_q   <= r1_q * a_diff_q;
    b_x2_q   <= a_s_q;
    // log difference to magnitude and sign
    c_neg_q  <= ld_diff[DiffW-1];
    c_mag_q  <= ld_diff[DiffW-1] ? DiffW'(-ld_diff) : DiffW'(ld_diff);
    d_prod_q <= c_mag_q * Ln2Q32;
    d_neg_q2 <= c_neg_q;
    // ln in Q.16, rounded half away from zero
    e_lmag_q <= LmagW'((d_prod_q + (64'd1 << 39)) >> 40);
    e_lneg_q <= d_neg_q2;
    f_l2_q   <= e_lmag_q * e_lmag_q;
    f_lmag_q <= e_lmag_q;
    f_lneg_q <= e_lneg_q;
    g_p3_q   <= f_l2_q * f_lmag_q;
    g_lmag_q <= f_lmag_q;
    g_lneg_q <= f_lneg_q;
    h_l3_q   <= L3W'(({1'b0, g_p3_q} + 64'(1 << 15)) >> 16);
    h_lmag_q <= g_lmag_q;
    h_lneg_q <= g_lneg_q;
    // partial products of the linear and cubic terms
    i_pb_lo_q <= b_mag_q[31:0] * h_lmag_q;
    i_pb_hi_q <= b_mag_q[47:32] * h_lmag_q;
    i_pd00_q  <= d_mag_q[23:0] * h_l3_q[23:0];
    i_pd01_q  <= d_mag_q[23:0] * h_l3_q[46:24];
    i_pd10_q  <= d_mag_q[47:24] * h_l3_q[23:0];
    i_pd11_q  <= d_mag_q[47:24] * h_l3_q[46:24];
    i_bneg_q  <= b_neg_q ^ h_lneg_q;
    i_dneg_q  <= d_neg_q ^ h_lneg_q;
    j_sb_q    <= 69'(i_pb_lo_q) + (69'(i_pb_hi_q) << 32);
    j_sd_q    <= 95'(i_pd00_q) + ((95'(i_pd01_q) + 95'(i_pd10_q)) << 24)
               + (95'(i_pd11_q) << 48);
    j_bneg_q  <= i_bneg_q;
    j_dneg_q  <= i_dneg_q;
    k_t1_q    <= j_bneg_q ? -$signed(64'(k_t1_mag)) : $signed(64'(k_t1_mag));
    k_t2_q    <= j_dneg_q ? -$signed(64'(k_t2_mag)) : $signed(64'(k_t2_mag));
    l_den_q   <= 64'(coef_a_q) + k_t1_q + k_t2_q;
    m_den_q   <= l_den_q[DenW-1:0];
  end

  ntc_log_diff #(
    .ADC_BITS(ADC_BITS)
  ) u_log_diff (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (b_ctl_q),
    .x1_i   (b_x1_q),
    .x2_i   (b_x2_q),
    .ctl_o  (ld_ctl),
    .diff_o (ld_diff)
  );

  ntc_recip u_recip (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (m_ctl_q),
    .den_i  (m_den_q),
    .ctl_o  (dv_ctl),
    .quot_o (dv_quot)
  );

  // kelvin offset, rounding to 1/256 degree and saturation
  logic signed [KelvinW-1:0]  t_kel, t_rnd;
  logic signed [TempBits+1:0] t_fix;
  logic signed [TempBits-1:0] temp_d, temp_q;
  logic                       done_q, vres_q;

  always_comb begin
    t_kel = $signed({2'b00, dv_quot}) - KelvinQ16;
    t_rnd = t_kel + TempRound;
    t_fix = 26'(t_rnd >>> 8);
    if (!dv_ctl.ok) begin
      temp_d = '0;
    end else if (dv_ctl.sat || (t_fix > TempMax)) begin
      temp_d = TempMax;
    end else if (t_fix < TempMin) begin
      temp_d = TempMin;
    end else begin
      temp_d = t_fix[TempBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_ctl.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    temp_q <= temp_d;
    vres_q <= dv_ctl.ok;
  end

  assign done_o        = done_q;
  assign temperature_o = temp_q;
  assign valid_res_o   = vres_q;

endmodule

### sv/ntc_log_diff.sv
// ----------------------------------------------------------------------------
// ntc_log_diff
// Two-lane pipelined log2 (Q.24, one squaring round per stage) and the
// difference of the two logs.
// ----------------------------------------------------------------------------
module ntc_log_diff
  import ntc_pkg::*;
#(
  parameter int unsigned ADC_BITS = AdcBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ntc_ctl_t                    ctl_i,
  input  logic [ADC_BITS+ResBits-1:0] x1_i,
  input  logic [ADC_BITS-1:0]         x2_i,
  output ntc_ctl_t                    ctl_o,
  output logic signed [DiffW-1:0]     diff_o
);

  localparam int unsigned XW = ADC_BITS + ResBits;
  localparam int unsigned KW = $clog2(XW);
  localparam int unsigned R  = LogFracBits;

  logic [XW-1:0]   x   [2];
  logic [KW-1:0]   k_d [2];
  logic [31:0]     m_d [2];

  logic [KW-1:0]   k_q [2][R];
  logic [31:0]     m_q [2][R];
  logic [R-1:0]    f_q [2][R];
  logic [31:0]     m_nx [2][R];
  logic [R-1:0]    f_nx [2][R];
  ntc_ctl_t        ctl_q [R];

  ntc_ctl_t                ctl_out_q;
  logic signed [DiffW-1:0] diff_q;

  assign x[0] = x1_i;
  assign x[1] = XW'(x2_i);

  // normalize: top set bit index and mantissa aligned to bit 31
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      k_d[l] = '0;
      for (int i = 0; i < XW; i++) begin
        if (x[l][i]) k_d[l] = KW'(i);
      end
      m_d[l] = 32'({x[l], 31'b0} >> k_d[l]);
    end
  end

  // one squaring round per stage
  always_comb begin
    logic [63:0] sq;
    logic [32:0] sh;
    sq = '0;
    sh = '0;
    for (int l = 0; l < 2; l++) begin
      for (int r = 0; r < R; r++) begin
        sq = m_q[l][r] * m_q[l][r];
        sh = sq[63:31];
        m_nx[l][r] = sh[32] ? sh[32:1] : sh[31:0];
        f_nx[l][r] = {f_q[l][r][R-2:0], sh[32]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < R; r++) ctl_q[r] <= '0;
      ctl_out_q <= '0;
    end else begin
      ctl_q[0] <= ctl_i;
      for (int r = 1; r < R; r++) ctl_q[r] <= ctl_q[r-1];
      ctl_out_q <= ctl_q[R-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 2; l++) begin
      k_q[l][0] <= k_d[l];
      m_q[l][0] <= m_d[l];
      f_q[l][0] <= '0;
      for (int r = 1; r < R; r++) begin
        k_q[l][r] <= k_q[l][r-1];
        m_q[l][r] <= m_nx[l][r-1];
        f_q[l][r] <= f_nx[l][r-1];
      end
    end
    diff_q <= DiffW'({k_q[0][R-1], f_nx[0][R-1]}) - DiffW'({k_q[1][R-1], f_nx[1][R-1]});
  end

  assign ctl_o  = ctl_out_q;
  assign diff_o = diff_q;

endmodule

### sv/ntc_recip.sv
// ----------------------------------------------------------------------------
// ntc_recip
// Pipelined restoring division of 2^56 by the denominator, giving the
// 32-bit quotient two bits per stage.
// ----------------------------------------------------------------------------
module ntc_recip
  import ntc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ntc_ctl_t            ctl_i,
  input  logic [DenW-1:0]     den_i,
  output ntc_ctl_t            ctl_o,
  output logic [QuotBits-1:0] quot_o
);

  localparam int unsigned Stages = QuotBits / DivStepBits;

  ntc_ctl_t            ctl_q  [Stages];
  logic [DenW-1:0]     den_q  [Stages];
  logic [DenW-1:0]     rem_q  [Stages];
  logic [DenW-1:0]     rem_d  [Stages];
  logic [QuotBits-1:0] quot_q [Stages];
  logic [QuotBits-1:0] quot_d [Stages];

  always_comb begin
    logic [DenW-1:0]     rem;
    logic [DenW-1:0]     dv;
    logic [QuotBits-1:0] qt;
    logic [DenW:0]       r2;
    rem = '0;
    dv  = '0;
    qt  = '0;
    r2  = '0;
    for (int s = 0; s < Stages; s++) begin
      if (s == 0) begin
        rem = RemInit;
        dv  = den_i;
        qt  = '0;
      end else begin
        rem = rem_q[s-1];
        dv  = den_q[s-1];
        qt  = quot_q[s-1];
      end
      for (int j = 0; j < DivStepBits; j++) begin
        r2 = {rem, 1'b0};
        if (r2 >= {1'b0, dv}) begin
          rem = DenW'(r2 - {1'b0, dv});
          qt  = {qt[QuotBits-2:0], 1'b1};
        end else begin
          rem = r2[DenW-1:0];
          qt  = {qt[QuotBits-2:0], 1'b0};
        end
      end
      rem_d[s]  = rem;
      quot_d[s] = qt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Stages; s++) ctl_q[s] <= '0;
    end else begin
      ctl_q[0] <= ctl_i;
      for (int s = 1; s < Stages; s++) ctl_q[s] <= ctl_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    den_q[0] <= den_i;
    for (int s = 1; s < Stages; s++) den_q[s] <= den_q[s-1];
    for (int s = 0; s < Stages; s++) begin
      rem_q[s]  <= rem_d[s];
      quot_q[s] <= quot_d[s];
    end
  end

  assign ctl_o  = ctl_q[Stages-1];
  assign quot_o = quot_q[Stages-1];

endmodule

### tb/tb_ntc_adc_to_temperature.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ntc_adc_to_temperature
// Self-checking testbench of the NTC thermistor temperature converter.
// The test writes several register settings, the extremes among them. For
// each setting it sends random samples, for some also directed ones, with
// random gaps. A fixed-point Steinhart-Hart model in the scoreboard predicts
// every result. The checker compares each, in order, with its prediction.
// ----------------------------------------------------------------------------
module tb_ntc_adc_to_temperature;
  import ntc_pkg::*;

  typedef struct {
    logic signed [TempBits-1:0] temp;
    logic                       ok;
    logic [AdcBits-1:0]         sample;
  } temp_exp_t;

  class temp_scoreboard;
    logic [AdcBits-1:0]         full_scale;
    logic [ResBits-1:0]         div_res;
    logic signed [CoefBits-1:0] coef_a, coef_b, coef_d;
    temp_exp_t                  pending[$];
    int                         errors;

    function new();
      full_scale = AdcBits'(FullScaleRst);
      div_res    = DivResRst;
      coef_a     = CoefARst;
      coef_b     = -$signed(CoefBMagRst);
      coef_d     = CoefDMagRst;
      errors     = 0;
    endfunction

    function void set_reg(ntc_cfg_e idx, logic [CoefBits-1:0] data);
      case (idx)
        CfgFullScale: full_scale = data[AdcBits-1:0];
        CfgDivRes:    div_res = data[ResBits-1:0];
        CfgCoeffA:    coef_a = data;
        CfgCoeffB:    coef_b = data;
        CfgCoeffD:    coef_d = data;
        default: ;
      endcase
    endfunction

    function logic [63:0] log2_q24(logic [63:0] x);
      int          k;
      logic [63:0] m, frac;
      k = 0;
      frac = '0;
      for (int i = 0; i < 64; i++) if (x[i]) k = i;
      m = (k >= 31) ? (x >> (k - 31)) : (x << (31 - k));
      for (int i = 0; i < 24; i++) begin
        m = (m * m) >> 31;
        frac = frac << 1;
        if (m >= 64'h1_0000_0000) begin
          frac[0] = 1'b1;
          m = m >> 1;
        end
      end
      return (64'(k) << 24) | frac;
    endfunction

    // product scaled by 2^-sh, rounded half away from zero
    function longint round_mul(longint a, longint b, int sh);
      logic [127:0] ua, ub, p;
      longint       r;
      ua = (a < 0) ? 128'(-a) : 128'(a);
      ub = (b < 0) ? 128'(-b) : 128'(b);
      p = ua * ub + (128'd1 << (sh - 1));
      r = {1'b0, p[sh +: 63]};
      return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function void note_sample(logic [AdcBits-1:0] s);
      temp_exp_t   e;
      longint      d, l, l3, den, t;
      logic [63:0] k;
      e.temp = '0;
      e.ok = 1'b0;
      e.sample = s;
      if (s != 0 && s < full_scale && div_res != 0) begin
        d = log2_q24(64'(div_res) * 64'(full_scale - s)) - log2_q24(64'(s));
        l = round_mul(d, 64'd2977044472, 40);
        l3 = round_mul(l * l, l, 16);
        den = longint'(coef_a) + round_mul(longint'(coef_b), l, 16)
            + round_mul(longint'(coef_d), l3, 32);
        if (den > 0) begin
          k = (64'd1 << 56) / 64'(den);
          t = longint'(k) - 17901158;
          t = (t + 128) >>> 8;
          if (t > 8388607) t = 8388607;
          if (t < -8388608) t = -8388608;
          e.temp = t[TempBits-1:0];
          e.ok = 1'b1;
        end
      end
      pending.push_back(e);
    endfunction

    function void check_result(logic signed [TempBits-1:0] temp, logic ok);
      temp_exp_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result temp=%0d ok=%0b", temp, ok);
        return;
      end
      e = pending.pop_front();
      if (temp !== e.temp || ok !== e.ok) begin
        errors++;
        if (errors <= 10)
          $display("sample %0d: expected temp=%0d ok=%0b, got temp=%0d ok=%0b",
                   e.sample, e.temp, e.ok, temp, ok);
      end
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [AdcBits-1:0]         adc_sample_i = '0;
  logic                       done_o;
  logic signed [TempBits-1:0] temperature_o;
  logic                       valid_res_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CfgIdxBits-1:0]      cfg_index_i = '0;
  logic [CoefBits-1:0]        cfg_data_i = '0;

  temp_scoreboard sb = new();
  int             gap_mode;

  ntc_adc_to_temperature dut (.*);

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(temperature_o, valid_res_o);
  end

  function automatic int pick_gap();
    if (gap_mode == 0) return 0;
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic send_sample(logic [AdcBits-1:0] s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    adc_sample_i <= s;
    do @(posedge clk_i); while (busy);
    sb.note_sample(s);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // registers change only with the pipeline empty
  task automatic write_reg(ntc_cfg_e idx, logic [CoefBits-1:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_run(int n);
    logic [AdcBits-1:0] s;
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) gap_mode = $urandom_range(0, 3);
      if ($urandom_range(0, 19) == 0) s = AdcBits'($urandom());
      else if (sb.full_scale > 1) s = AdcBits'($urandom_range(1, sb.full_scale - 1));
      else s = AdcBits'($urandom());
      send_sample(s);
    end
  endtask

  localparam logic [CoefBits-1:0] CoefMax = 48'h7FFF_FFFF_FFFF;
  localparam logic [CoefBits-1:0] CoefMin = 48'h8000_0000_0000;

  initial begin
    logic [CoefBits-1:0] rnd;
    logic [AdcBits-1:0]  dir_s [8];
    dir_s = '{12'd0, 12'd1, 12'd2, 12'd2047, 12'd4094, 12'd4095, 12'hAAA, 12'h555};
    gap_mode = 1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: range edges and bit patterns
    foreach (dir_s[i]) send_sample(dir_s[i]);
    random_run(250);
    drain();

    // smaller full scale, samples at and above it, high divider bits
    write_reg(CfgFullScale, 48'hFFF_FFFF_F800);
    write_reg(CfgDivRes, 48'hFFFF_FFFF_FFFF);
    send_sample(12'd2048);
    send_sample(12'd3000);
    send_sample(12'd2047);
    random_run(200);
    drain();

    // zero divider and full scale of one: never valid
    write_reg(CfgDivRes, 48'd0);
    send_sample(12'd100);
    write_reg(CfgDivRes, 48'd1);
    write_reg(CfgFullScale, 48'd1);
    send_sample(12'd0);
    send_sample(12'd1);
    random_run(60);
    drain();

    // tiny denominator saturates high, negative one is invalid
    write_reg(CfgFullScale, 48'd4095);
    write_reg(CfgDivRes, 48'd1000);
    write_reg(CfgCoeffA, 48'd1);
    write_reg(CfgCoeffB, 48'd0);
    write_reg(CfgCoeffD, 48'd0);
    send_sample(12'd1000);
    write_reg(CfgCoeffA, CoefMin);
    send_sample(12'd1000);
    write_reg(CfgCoeffA, CoefMax);
    send_sample(12'd1000);
    random_run(100);
    drain();

    // extreme slopes
    write_reg(CfgCoeffB, CoefMin);
    write_reg(CfgCoeffD, CoefMax);
    random_run(150);
    drain();
    write_reg(CfgCoeffB, CoefMax);
    write_reg(CfgCoeffD, CoefMin);
    random_run(150);
    drain();

    // random settings around the defaults and fully random ones
    for (int p = 0; p < 6; p++) begin
      write_reg(CfgFullScale, 48'($urandom_range(2, 4095)));
      write_reg(CfgDivRes, 48'($urandom_range(1, 1048575)));
      if (p < 3) begin
        write_reg(CfgCoeffA, 48'(64'sd11651736815 + $signed($urandom_range(0, 1 << 28))));
        write_reg(CfgCoeffB, 48'(-64'sd2600987715 + $signed($urandom_range(0, 1 << 26))));
        write_reg(CfgCoeffD, 48'($urandom_range(0, 1 << 26)));
      end else begin
        rnd = 48'({$urandom(), $urandom()});
        write_reg(CfgCoeffA, rnd);
        rnd = 48'({$urandom(), $urandom()});
        write_reg(CfgCoeffB, rnd);
        rnd = 48'({$urandom(), $urandom()});
        write_reg(CfgCoeffD, rnd);
      end
      random_run(120);
      drain();
    end

    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### ntc_adc_to_temperature.f
sv/ntc_pkg.sv
sv/ntc_log_diff.sv
sv/ntc_recip.sv
sv/ntc_adc_to_temperature.sv
tb/tb_ntc_adc_to_temperature.sv
